@@ rtl/ppd_pkg.sv @@
// Package with widths, register map, shared types and helpers of the plane deflector.
`default_nettype none
package ppd_pkg;

	// Field and register widths.
	localparam int W       = 32;
	localparam int NW      = 16;
	localparam int DT_W    = 24;
	localparam int BNC_W   = 17;
	localparam int FRAC_F  = 24;
	localparam int Q_W     = FRAC_F + 1;

	// Internal arithmetic widths, sized to hold every value exactly.
	localparam int PST_W   = W + DT_W + 1;
	localparam int STEP_W  = PST_W - 16;
	localparam int NPOS_W  = W + NW;
	localparam int A_W     = NPOS_W + 3;
	localparam int NST_W   = STEP_W + NW;
	localparam int NS_W    = NST_W + 2;
	localparam int DEN_W   = NS_W - 1;
	localparam int VDN_W   = NPOS_W + 2;
	localparam int VN_W    = VDN_W - 14;
	localparam int RFP_W   = VN_W + NW;
	localparam int RF_W    = RFP_W - 13;
	localparam int RV_W    = RF_W + 1;
	localparam int HITP_W  = STEP_W + Q_W + 1;
	localparam int HIT_W   = STEP_W;
	localparam int HD_W    = HIT_W + 1;
	localparam int OVP_W   = HD_W + BNC_W + 1;
	localparam int OV_W    = OVP_W - 16;
	localparam int RVP_W   = RV_W + BNC_W + 1;
	localparam int RVB_W   = RVP_W - 16;
	localparam int SUM_W   = OV_W + 2;

	// Register map, index = byte address / 4.
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_POINT_X  = 3'd3;
	localparam logic [2:0] REG_POINT_Y  = 3'd4;
	localparam logic [2:0] REG_POINT_Z  = 3'd5;
	localparam logic [2:0] REG_BOUNCE   = 3'd6;

	// Plane configuration as seen by the datapath.
	typedef struct packed {
		logic [2:0][NW-1:0] n;
		logic [2:0][W-1:0]  p;
		logic [BNC_W-1:0]   bnc;
	} cfg_t;

	// Particle state leaving the plane test.
	typedef struct packed {
		logic                   defl;
		logic                   last;
		logic [2:0][W-1:0]      pos;
		logic [2:0][W-1:0]      vel;
		logic [2:0][STEP_W-1:0] step;
		logic [VN_W-1:0]        vn16;
		logic [DEN_W-1:0]       num;
		logic [DEN_W-1:0]       den;
	} fr_t;

	// One divider stage: particle state plus partial remainder and quotient.
	typedef struct packed {
		fr_t              d;
		logic [DEN_W:0]   r;
		logic [Q_W-1:0]   q;
	} dst_t;

	// Clamp to the signed 32-bit range.
	function automatic logic [W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -hi - SUM_W'(1);
		if (x > hi) begin
			return hi[W-1:0];
		end else if (x < lo) begin
			return lo[W-1:0];
		end
		return x[W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/ppd_if.sv @@
// Stream interfaces for particles in and results out.
`default_nettype none
interface ppd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic [23:0]        time_step;
	logic               batch_end;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step,
		batch_end, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step,
		batch_end, output ready);
endinterface

interface ppd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_pos_x;
	logic signed [31:0] new_pos_y;
	logic signed [31:0] new_pos_z;
	logic signed [31:0] new_vel_x;
	logic signed [31:0] new_vel_y;
	logic signed [31:0] new_vel_z;
	logic               deflected;
	logic               batch_end_out;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, deflected, batch_end_out, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, deflected, batch_end_out, output ready);
endinterface
`default_nettype wire

@@ rtl/ppd_front.sv @@
// Front pipeline: step, plane distances and the deflection test over three stages.
`default_nettype none
module ppd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire ppd_pkg::cfg_t cfg,
	ppd_in_if.sink            in_ch,
	output logic              v_out,
	output ppd_pkg::fr_t      fr_out
);
	import ppd_pkg::*;

	logic signed [NW-1:0]     nn [3];
	logic signed [W-1:0]      pp [3];
	logic signed [W-1:0]      pin [3];
	logic signed [W-1:0]      vin [3];
	logic signed [DT_W:0]     dt;

	logic                     v_s1, v_s2;
	logic signed [PST_W-1:0]  pst_s1 [3];
	logic signed [NPOS_W-1:0] npos_s1 [3];
	logic signed [NPOS_W-1:0] npt_s1 [3];
	logic signed [NPOS_W-1:0] nvel_s1 [3];
	logic [W-1:0]             pos_s1 [3];
	logic [W-1:0]             vel_s1 [3];
	logic                     last_s1;

	logic signed [PST_W-1:0]  sh_c [3];
	logic signed [STEP_W-1:0] step_c [3];
	logic signed [A_W-1:0]    a_c;
	logic signed [VDN_W-1:0]  vdn_c;

	logic signed [STEP_W-1:0] step_s2 [3];
	logic signed [NST_W-1:0]  nst_s2 [3];
	logic signed [A_W-1:0]    a_s2;
	logic signed [VDN_W-1:0]  vdn_s2;
	logic [W-1:0]             pos_s2 [3];
	logic [W-1:0]             vel_s2 [3];
	logic                     last_s2;

	logic signed [NS_W-1:0]   ns_c;
	logic signed [NS_W-1:0]   after_c;
	logic signed [NS_W-1:0]   den_c;
	logic signed [NS_W-1:0]   num_c;
	logic signed [VDN_W-1:0]  vn_c;

	assign in_ch.ready = adv;

	// Unpack configuration and the incoming transaction.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nn[i] = $signed(cfg.n[i]);
			pp[i] = $signed(cfg.p[i]);
		end
		pin[0] = in_ch.pos_x;
		pin[1] = in_ch.pos_y;
		pin[2] = in_ch.pos_z;
		vin[0] = in_ch.vel_x;
		vin[1] = in_ch.vel_y;
		vin[2] = in_ch.vel_z;
		dt     = $signed({1'b0, in_ch.time_step});
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_ch.valid;
			v_s2  <= v_s1;
			v_out <= v_s2;
		end
	end

	// Stage 1: the raw products.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pst_s1[i]  <= vin[i] * dt;
				npos_s1[i] <= nn[i] * pin[i];
				npt_s1[i]  <= nn[i] * pp[i];
				nvel_s1[i] <= nn[i] * vin[i];
				pos_s1[i]  <= pin[i];
				vel_s1[i]  <= vin[i];
			end
			last_s1 <= in_ch.batch_end;
		end
	end

	// Stage 2: step, its projection on the normal, and the start distance.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i]   = pst_s1[i] >>> 16;
			step_c[i] = sh_c[i][STEP_W-1:0];
		end
		a_c   = npos_s1[0] + npos_s1[1] + npos_s1[2] - npt_s1[0] - npt_s1[1] - npt_s1[2];
		vdn_c = nvel_s1[0] + nvel_s1[1] + nvel_s1[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				step_s2[i] <= step_c[i];
				nst_s2[i]  <= nn[i] * step_c[i];
				pos_s2[i]  <= pos_s1[i];
				vel_s2[i]  <= vel_s1[i];
			end
			a_s2    <= a_c;
			vdn_s2  <= vdn_c;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: distance after the step and the crossing test.
	always_comb begin
		ns_c    = nst_s2[0] + nst_s2[1] + nst_s2[2];
		num_c   = a_s2;
		after_c = num_c + ns_c;
		den_c   = -ns_c;
		vn_c    = vdn_s2 >>> 14;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_out.defl <= (a_s2 > 0) && (after_c <= 0);
			fr_out.last <= last_s2;
			for (int i = 0; i < 3; i++) begin
				fr_out.pos[i]  <= pos_s2[i];
				fr_out.vel[i]  <= vel_s2[i];
				fr_out.step[i] <= step_s2[i];
			end
			fr_out.vn16 <= vn_c[VN_W-1:0];
			fr_out.num  <= num_c[DEN_W-1:0];
			fr_out.den  <= den_c[DEN_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/ppd_div.sv @@
// Pipelined restoring divider for the hit fraction, one quotient bit per stage.
`default_nettype none
module ppd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        v_in,
	input  wire ppd_pkg::fr_t fr_in,
	output logic             v_out,
	output ppd_pkg::dst_t    dv_out
);
	import ppd_pkg::*;

	dst_t           div_s [Q_W];
	logic [Q_W-1:0] v_s;
	dst_t           prev_c [Q_W];
	logic [DEN_W:0] rs_c [Q_W];
	logic           ge_c [Q_W];

	// Remainder shift, compare and subtract for each stage.
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				prev_c[k].d = fr_in;
				prev_c[k].r = {1'b0, fr_in.num};
				prev_c[k].q = '0;
				rs_c[k]     = {1'b0, fr_in.num};
			end else begin
				prev_c[k] = div_s[k-1];
				rs_c[k]   = {div_s[k-1].r[DEN_W-1:0], 1'b0};
			end
			ge_c[k] = rs_c[k] >= {1'b0, prev_c[k].d.den};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[Q_W-2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < Q_W; k++) begin
				div_s[k].d <= prev_c[k].d;
				div_s[k].r <= ge_c[k] ? rs_c[k] - {1'b0, prev_c[k].d.den} : rs_c[k];
				div_s[k].q <= {prev_c[k].q[Q_W-2:0], ge_c[k]};
			end
		end
	end

	assign v_out  = v_s[Q_W-1];
	assign dv_out = div_s[Q_W-1];

endmodule
`default_nettype wire

@@ rtl/ppd_back.sv @@
// Back pipeline: hit point, mirrored overshoot, reflected velocity and the result register.
`default_nettype none
module ppd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ppd_pkg::cfg_t  cfg,
	input  wire logic          v_in,
	input  wire ppd_pkg::dst_t  dv_in,
	output logic               adv,
	ppd_out_if.source          out_ch
);
	import ppd_pkg::*;

	logic signed [NW-1:0]     nn [3];
	logic signed [BNC_W:0]    bnc;
	logic signed [Q_W:0]      f_c;

	logic                     v_s1, v_s2, v_s3, v_q;
	logic signed [HITP_W-1:0] hitp_s1 [3];
	logic signed [RFP_W-1:0]  rfp_s1 [3];
	logic signed [STEP_W-1:0] step_s1 [3];
	logic signed [W-1:0]      pos_s1 [3];
	logic signed [W-1:0]      vel_s1 [3];
	logic                     defl_s1, last_s1;

	logic signed [HITP_W-1:0] hsh_c [3];
	logic signed [RFP_W-1:0]  rsh_c [3];
	logic signed [HIT_W-1:0]  hit_c [3];
	logic signed [RF_W-1:0]   rf_c [3];

	logic signed [HIT_W-1:0]  hit_s2 [3];
	logic signed [HD_W-1:0]   hd_s2 [3];
	logic signed [RV_W-1:0]   rv_s2 [3];
	logic signed [W-1:0]      pos_s2 [3];
	logic signed [W-1:0]      vel_s2 [3];
	logic                     defl_s2, last_s2;

	logic signed [HIT_W-1:0]  hit_s3 [3];
	logic signed [OVP_W-1:0]  ovp_s3 [3];
	logic signed [RVP_W-1:0]  rvp_s3 [3];
	logic signed [W-1:0]      pos_s3 [3];
	logic signed [W-1:0]      vel_s3 [3];
	logic                     defl_s3, last_s3;

	logic signed [OVP_W-1:0]  osh_c [3];
	logic signed [RVP_W-1:0]  vsh_c [3];
	logic signed [SUM_W-1:0]  psum_c [3];
	logic signed [SUM_W-1:0]  vsum_c [3];
	logic [W-1:0]             npos_c [3];
	logic [W-1:0]             nvel_c [3];

	logic [W-1:0]             npos_q [3];
	logic [W-1:0]             nvel_q [3];
	logic                     defl_q, last_q;

	// The whole pipeline moves unless a result is held by the receiver.
	assign adv = !v_q || out_ch.ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nn[i] = $signed(cfg.n[i]);
		end
		bnc = $signed({1'b0, cfg.bnc});
		f_c = $signed({1'b0, dv_in.q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_q  <= v_s3;
		end
	end

	// Stage 1: step times fraction, and the normal velocity times the normal.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				hitp_s1[i] <= $signed(dv_in.d.step[i]) * f_c;
				rfp_s1[i]  <= $signed(dv_in.d.vn16) * nn[i];
				step_s1[i] <= $signed(dv_in.d.step[i]);
				pos_s1[i]  <= $signed(dv_in.d.pos[i]);
				vel_s1[i]  <= $signed(dv_in.d.vel[i]);
			end
			defl_s1 <= dv_in.d.defl;
			last_s1 <= dv_in.d.last;
		end
	end

	// Stage 2: scale down, overshoot vector and reflected velocity.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hsh_c[i] = hitp_s1[i] >>> FRAC_F;
			hit_c[i] = hsh_c[i][HIT_W-1:0];
			// Twice the product, floored by 2^14, is the product floored by 2^13.
			rsh_c[i] = rfp_s1[i] >>> 13;
			rf_c[i]  = rsh_c[i][RF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				hit_s2[i] <= hit_c[i];
				hd_s2[i]  <= hit_c[i] - step_s1[i];
				rv_s2[i]  <= vel_s1[i] - rf_c[i];
				pos_s2[i] <= pos_s1[i];
				vel_s2[i] <= vel_s1[i];
			end
			defl_s2 <= defl_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: apply the bounce factor.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				hit_s3[i] <= hit_s2[i];
				ovp_s3[i] <= hd_s2[i] * bnc;
				rvp_s3[i] <= rv_s2[i] * bnc;
				pos_s3[i] <= pos_s2[i];
				vel_s3[i] <= vel_s2[i];
			end
			defl_s3 <= defl_s2;
			last_s3 <= last_s2;
		end
	end

	// Final sums, saturation and the pass-through choice.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			osh_c[i]  = ovp_s3[i] >>> 16;
			vsh_c[i]  = rvp_s3[i] >>> 16;
			psum_c[i] = SUM_W'(pos_s3[i]) + SUM_W'(hit_s3[i])
				+ SUM_W'($signed(osh_c[i][OV_W-1:0]));
			vsum_c[i] = SUM_W'($signed(vsh_c[i][RVB_W-1:0]));
			if (defl_s3) begin
				npos_c[i] = sat32(psum_c[i]);
				nvel_c[i] = sat32(vsum_c[i]);
			end else begin
				npos_c[i] = pos_s3[i];
				nvel_c[i] = vel_s3[i];
			end
		end
	end

	// Result register facing the output channel.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				npos_q[i] <= npos_c[i];
				nvel_q[i] <= nvel_c[i];
			end
			defl_q <= defl_s3;
			last_q <= last_s3;
		end
	end

	assign out_ch.valid         = v_q;
	assign out_ch.new_pos_x     = npos_q[0];
	assign out_ch.new_pos_y     = npos_q[1];
	assign out_ch.new_pos_z     = npos_q[2];
	assign out_ch.new_vel_x     = nvel_q[0];
	assign out_ch.new_vel_y     = nvel_q[1];
	assign out_ch.new_vel_z     = nvel_q[2];
	assign out_ch.deflected     = defl_q;
	assign out_ch.batch_end_out = last_q;

endmodule
`default_nettype wire

@@ rtl/particle_plane_deflector.sv @@
// Top level of the particle plane deflector: register file and pipeline assembly.
//
// Particles arrive on particle_in as valid/ready transactions carrying position,
// velocity, time step and a batch marker. Each particle produces exactly one
// transaction on particle_out, in order: the reflected position and velocity
// when it crosses the plane during the step, else its inputs unchanged.
// The plane normal, a point on it and the bounce factor are set through the
// APB port at byte addresses 0x00 to 0x18; write them only while the pipeline
// is empty. Reads return the register values.
// From input transaction to result, a particle passes the plane test stages,
// the fraction divider (one quotient bit per stage), the reflection
// arithmetic stages and the result register. Every stage carries a valid bit.
// Throughput is one particle per cycle while results are accepted.
// When the receiver holds off ready while a result waits, the whole pipeline
// freezes and particle_in.ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the default plane: normal along +y
// through the origin, bounce of one.
`default_nettype none
module particle_plane_deflector (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ppd_in_if.sink                    particle_in,
	ppd_out_if.source                 particle_out,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ppd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import ppd_pkg::*;

	cfg_t       cfg_q;
	logic       adv;
	logic       fr_v;
	fr_t        fr;
	logic       dv_v;
	dst_t       dv;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n[0] <= 16'sd0;
			cfg_q.n[1] <= 16'sd16384;
			cfg_q.n[2] <= 16'sd0;
			cfg_q.p[0] <= '0;
			cfg_q.p[1] <= '0;
			cfg_q.p[2] <= '0;
			cfg_q.bnc  <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_NORMAL_X: cfg_q.n[0] <= pwdata[NW-1:0];
				REG_NORMAL_Y: cfg_q.n[1] <= pwdata[NW-1:0];
				REG_NORMAL_Z: cfg_q.n[2] <= pwdata[NW-1:0];
				REG_POINT_X:  cfg_q.p[0] <= pwdata;
				REG_POINT_Y:  cfg_q.p[1] <= pwdata;
				REG_POINT_Z:  cfg_q.p[2] <= pwdata;
				REG_BOUNCE:   cfg_q.bnc  <= pwdata[BNC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback, sign-extended where the register is signed.
	always_comb begin
		case (idx)
			REG_NORMAL_X: prdata = {{(32-NW){cfg_q.n[0][NW-1]}}, cfg_q.n[0]};
			REG_NORMAL_Y: prdata = {{(32-NW){cfg_q.n[1][NW-1]}}, cfg_q.n[1]};
			REG_NORMAL_Z: prdata = {{(32-NW){cfg_q.n[2][NW-1]}}, cfg_q.n[2]};
			REG_POINT_X:  prdata = cfg_q.p[0];
			REG_POINT_Y:  prdata = cfg_q.p[1];
			REG_POINT_Z:  prdata = cfg_q.p[2];
			REG_BOUNCE:   prdata = {{(32-BNC_W){1'b0}}, cfg_q.bnc};
			default:      prdata = '0;
		endcase
	end

	ppd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.in_ch  (particle_in),
		.v_out  (fr_v),
		.fr_out (fr)
	);

	ppd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (fr_v),
		.fr_in  (fr),
		.v_out  (dv_v),
		.dv_out (dv)
	);

	ppd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.v_in   (dv_v),
		.dv_in  (dv),
		.adv    (adv),
		.out_ch (particle_out)
	);

endmodule
`default_nettype wire

@@ dv/tb_particle_plane_deflector.sv @@
// Self-checking testbench for the particle plane deflector: directed table, then random streams.
`default_nettype none
module tb_particle_plane_deflector;
	timeunit 1ns;
	timeprecision 1ps;
	import ppd_pkg::*;

	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 20000;

	// One particle and one result, as the block sees them.
	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
		logic [23:0]        dt;
		logic               last;
	} particle_t;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
		logic               defl;
		logic               last;
	} bounce_res_t;

	// Directed table row: particle plus an optional typed-in expectation.
	typedef struct {
		particle_t   p;
		bit          has_exp;
		bounce_res_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ppd_in_if  pin ();
	ppd_out_if pout ();

	particle_plane_deflector dut (
		.clk(clk), .arst_n(arst_n), .particle_in(pin.sink), .particle_out(pout.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the plane registers.
	logic signed [15:0] sh_n [3];
	logic signed [31:0] sh_p [3];
	logic [16:0]        sh_bnc;

	bounce_res_t expected_q [$];
	int  errors = 0;
	int  send_idle_pct = 0, recv_idle_pct = 0;
	bit  recv_hold = 1'b0;
	int  idle_cycles = 0;

	initial begin
		pin.valid = 1'b0;
		pin.pos_x = '0; pin.pos_y = '0; pin.pos_z = '0;
		pin.vel_x = '0; pin.vel_y = '0; pin.vel_z = '0;
		pin.time_step = '0; pin.batch_end = 1'b0;
		pout.ready = 1'b0;
	end

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// Computes the outcome of one particle against the current plane.
	function automatic bounce_res_t deflect_particle(particle_t p);
		bounce_res_t r;
		longint nn [3], st [3];
		longint np, a, ns, after, vdn, vn16, hit, over, refl, rv, bnc, dt;
		longint unsigned num, den, rem, q;
		np = 0; a = 0; ns = 0; vdn = 0;
		dt = longint'(p.dt);
		bnc = longint'(sh_bnc);
		for (int i = 0; i < 3; i++) begin
			nn[i] = longint'(sh_n[i]);
			st[i] = floor_sh(longint'(p.vel[i]) * dt, 16);
			np += nn[i] * longint'(sh_p[i]);
			a += nn[i] * longint'(p.pos[i]);
			ns += nn[i] * st[i];
			vdn += longint'(p.vel[i]) * nn[i];
		end
		a -= np;
		after = a + ns;
		r.last = p.last;
		if (a > 0 && after <= 0) begin
			num = a; den = a - after;
			rem = num; q = 0;
			if (rem >= den) begin q = 1; rem -= den; end
			for (int k = 0; k < FRAC_F; k++) begin
				rem = rem << 1; q = q << 1;
				if (rem >= den) begin q |= 1; rem -= den; end
			end
			vn16 = floor_sh(vdn, 14);
			for (int i = 0; i < 3; i++) begin
				hit = floor_sh(st[i] * longint'(q), FRAC_F);
				over = floor_sh((hit - st[i]) * bnc, 16);
				refl = floor_sh(2 * vn16 * nn[i], 14);
				rv = longint'(p.vel[i]) - refl;
				r.pos[i] = clamp32(longint'(p.pos[i]) + hit + over);
				r.vel[i] = clamp32(floor_sh(rv * bnc, 16));
			end
			r.defl = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				r.pos[i] = p.pos[i];
				r.vel[i] = p.vel[i];
			end
			r.defl = 1'b0;
		end
		return r;
	endfunction

	// APB write: setup then access cycle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z: sh_n[idx] = val[15:0];
			REG_POINT_X, REG_POINT_Y, REG_POINT_Z: sh_p[idx - REG_POINT_X] = val;
			REG_BOUNCE: sh_bnc = val[16:0];
			default: ;
		endcase
	endtask

	task automatic set_plane(logic signed [15:0] nx, logic signed [15:0] ny,
			logic signed [15:0] nz, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic [16:0] b);
		write_reg(REG_NORMAL_X, 32'(nx));
		write_reg(REG_NORMAL_Y, 32'(ny));
		write_reg(REG_NORMAL_Z, 32'(nz));
		write_reg(REG_POINT_X, px);
		write_reg(REG_POINT_Y, py);
		write_reg(REG_POINT_Z, pz);
		write_reg(REG_BOUNCE, 32'(b));
	endtask

	// Waits for all results, then lets the pipeline settle before a register write.
	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one particle and holds it until the transaction completes.
	task automatic send_particle(particle_t p, bit has_exp, bounce_res_t r);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			pin.valid <= 1'b0;
			@(posedge clk);
		end
		pin.valid <= 1'b1;
		pin.pos_x <= p.pos[0]; pin.pos_y <= p.pos[1]; pin.pos_z <= p.pos[2];
		pin.vel_x <= p.vel[0]; pin.vel_y <= p.vel[1]; pin.vel_z <= p.vel[2];
		pin.time_step <= p.dt; pin.batch_end <= p.last;
		@(posedge clk);
		while (!pin.ready) @(posedge clk);
		expected_q.push_back(has_exp ? r : deflect_particle(p));
	endtask

	task automatic end_burst();
		pin.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom();
			default: return $signed($urandom_range(2 * 65536 * 64)) - 32'sd8388608;
		endcase
	endfunction

	// Mostly particles that cross the plane within one step, plus wide noise.
	function automatic particle_t rnd_particle();
		particle_t p;
		bit crossing;
		crossing = ($urandom_range(99) < 70);
		for (int i = 0; i < 3; i++) begin
			if (crossing) begin
				p.pos[i] = sh_p[i] + $signed($urandom_range(65536 * 8)) - 32'sd262144;
				p.vel[i] = $signed($urandom_range(65536 * 64)) - 32'sd2097152;
			end else begin
				p.pos[i] = rnd_word();
				p.vel[i] = rnd_word();
			end
		end
		if (crossing) begin
			p.dt = $urandom_range(65536 * 2);
			for (int i = 0; i < 3; i++)
				if (sh_n[i] > 0) begin
					p.pos[i] = sh_p[i] + $signed($urandom_range(65536 * 2));
					p.vel[i] = -$signed($urandom_range(65536 * 16)) - 32'sd65536;
				end else if (sh_n[i] < 0) begin
					p.pos[i] = sh_p[i] - $signed($urandom_range(65536 * 2));
					p.vel[i] = $signed($urandom_range(65536 * 16)) + 32'sd65536;
				end
		end else begin
			p.dt = ($urandom_range(9) == 0) ? 24'hffffff : $urandom();
		end
		p.last = $urandom_range(1);
		return p;
	endfunction

	// Receiver: random idling plus an optional long hold-off.
	always @(posedge clk) begin
		if (recv_hold)
			pout.ready <= 1'b0;
		else
			pout.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		bounce_res_t e;
		if (arst_n && pout.valid && pout.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (pout.new_pos_x !== e.pos[0]) begin
					$error("new_pos_x exp %h got %h", e.pos[0], pout.new_pos_x); errors++;
				end
				if (pout.new_pos_y !== e.pos[1]) begin
					$error("new_pos_y exp %h got %h", e.pos[1], pout.new_pos_y); errors++;
				end
				if (pout.new_pos_z !== e.pos[2]) begin
					$error("new_pos_z exp %h got %h", e.pos[2], pout.new_pos_z); errors++;
				end
				if (pout.new_vel_x !== e.vel[0]) begin
					$error("new_vel_x exp %h got %h", e.vel[0], pout.new_vel_x); errors++;
				end
				if (pout.new_vel_y !== e.vel[1]) begin
					$error("new_vel_y exp %h got %h", e.vel[1], pout.new_vel_y); errors++;
				end
				if (pout.new_vel_z !== e.vel[2]) begin
					$error("new_vel_z exp %h got %h", e.vel[2], pout.new_vel_z); errors++;
				end
				if (pout.deflected !== e.defl) begin
					$error("deflected exp %b got %b", e.defl, pout.deflected); errors++;
				end
				if (pout.batch_end_out !== e.last) begin
					$error("batch_end_out exp %b got %b", e.last, pout.batch_end_out); errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((pin.valid && pin.ready) || (pout.valid && pout.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic particle_t mk(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz, logic [23:0] dt, logic last);
		particle_t p;
		p.pos[0] = px; p.pos[1] = py; p.pos[2] = pz;
		p.vel[0] = vx; p.vel[1] = vy; p.vel[2] = vz;
		p.dt = dt; p.last = last;
		return p;
	endfunction

	// Pass-through expectation: the particle comes back unchanged.
	function automatic dir_row_t row_pass(particle_t p);
		dir_row_t d;
		d.p = p; d.has_exp = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d.r.pos[i] = p.pos[i]; d.r.vel[i] = p.vel[i];
		end
		d.r.defl = 1'b0; d.r.last = p.last;
		return d;
	endfunction

	function automatic dir_row_t row_pred(particle_t p);
		dir_row_t d;
		d.p = p; d.has_exp = 1'b0;
		return d;
	endfunction

	int hold_len;
	dir_row_t dir_tab [$];
	bounce_res_t none;

	initial begin
		sh_n[0] = 0; sh_n[1] = 16384; sh_n[2] = 0;
		sh_p[0] = 0; sh_p[1] = 0; sh_p[2] = 0;
		sh_bnc = 17'd65536;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with the reset plane (y = 0, full bounce).
		dir_tab.push_back(row_pass(mk(0, 0, 0, 0, 0, 0, 0, 0)));
		dir_tab.push_back(row_pass(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 1)));
		dir_tab.push_back(row_pred(mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hffffff, 0)));
		// Zero time step: no deflection even when heading into the plane.
		dir_tab.push_back(row_pass(mk(0, 65536, 0, 0, -32'sd655360, 0, 0, 1)));
		// Straight down through the plane, exact hit at half step.
		dir_tab.push_back(row_pred(mk(0, 65536, 0, 0, -32'sd131072, 0, 24'd65536, 0)));
		// Lands exactly on the plane.
		dir_tab.push_back(row_pred(mk(100, 65536, -5, 7, -32'sd65536, 3, 24'd65536, 1)));
		// Starts on the plane: not strictly above, passes.
		dir_tab.push_back(row_pass(mk(1, 0, 2, 3, -32'sd65536, 4, 24'd65536, 0)));
		// Moving away from the plane.
		dir_tab.push_back(row_pass(mk(0, 65536, 0, 0, 32'sd65536, 0, 24'd65536, 0)));
		// Huge velocity and step, saturating results.
		dir_tab.push_back(row_pred(mk(32'sh7fffffff, 1, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 24'hffffff, 1)));
		dir_tab.push_back(row_pred(mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh7fffffff, 24'hffffff, 0)));
		dir_tab.push_back(row_pred(mk(12345, 3, -999, 32'sh40000000, -32'sd262144,
			-32'sd77, 24'h00ffff, 1)));
		foreach (dir_tab[i]) send_particle(dir_tab[i].p, dir_tab[i].has_exp, dir_tab[i].r);
		end_burst();
		wait_drained();

		// Extreme plane settings: negative normal, offset point, zero and max bounce.
		set_plane(-16384, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 17'd0);
		dir_tab.delete();
		dir_tab.push_back(row_pred(mk(-32'sd65536 * 32768 + 32'sd65536, 0, 0,
			-32'sd131072, 0, 0, 24'd65536, 0)));
		dir_tab.push_back(row_pred(mk(32'sh80000000, 5, 5, 32'sh7fffffff, 5, 5,
			24'hffffff, 1)));
		foreach (dir_tab[i]) send_particle(dir_tab[i].p, 0, none);
		end_burst();
		wait_drained();
		set_plane(16384, 16384, -16384, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			17'h1ffff);
		for (int i = 0; i < 10; i++) send_particle(rnd_particle(), 0, none);
		end_burst();
		wait_drained();

		// Random phases: plane changes between phases, idling per phase.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 26; recv_idle_pct = 51; end
				1: begin send_idle_pct = 51; recv_idle_pct = 26; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (ph)
				0: set_plane(0, 16384, 0, 0, 0, 0, 17'd65536);
				1: set_plane(9459, 9459, 9459, 32'sd65536, -32'sd65536, 32'sd300, 17'd32768);
				2: set_plane(0, 0, -16384, 0, 0, 32'sd1000000, 17'd65536);
				3: set_plane(16384, 0, 0, -32'sd5000, 0, 0, 17'd0);
				4: set_plane(11585, -11585, 0, 32'sd777, 32'sd888, 32'sd999, 17'h1ffff);
				5: set_plane(-20000, 30000, 5, 32'sh12345678, -32'sd3, 0, 17'd40000);
				6: set_plane(16384, 16384, 16384, 0, 0, 0, 17'd65536);
				default: set_plane($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom());
			endcase
			for (int k = 0; k < 250; k++) begin
				send_particle(rnd_particle(), 0, none);
				// Long receiver hold-off while the sender keeps offering.
				if (ph == 2 && k == 100) fork
					begin
						recv_hold = 1'b1;
						hold_len = 0;
						while (hold_len < 200) begin
							@(posedge clk);
							hold_len++;
						end
						recv_hold = 1'b0;
					end
				join_none
				// Sender pauses until every result has come back.
				if (ph == 4 && k == 120) begin
					end_burst();
					while (expected_q.size() != 0) @(posedge clk);
				end
			end
			end_burst();
			wait_drained();
		end

		if (errors == 0 && expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

@@ particle_plane_deflector.f @@
rtl/ppd_pkg.sv
rtl/ppd_if.sv
rtl/ppd_front.sv
rtl/ppd_div.sv
rtl/ppd_back.sv
rtl/particle_plane_deflector.sv
dv/tb_particle_plane_deflector.sv
